>>> hdl/rsa_modular_exponentiation_macros.svh
// Assertion macros used by the checker file of the RSA exponentiation block.
`ifndef RSA_MODULAR_EXPONENTIATION_MACROS_SVH
`define RSA_MODULAR_EXPONENTIATION_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define RME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/rme_pkg.sv
// Package with register codes, operation codes and shared types of the RSA block.
`timescale 1ns / 1ps
package rme_pkg;

	// APB address width: three registers at byte addresses 0, 4, 8
	localparam int ADDR_BITS = 4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_MODULUS  = 2'd0;
	localparam logic [1:0] REG_PUB_EXP  = 2'd1;
	localparam logic [1:0] REG_PRIV_EXP = 2'd2;

	// operation select
	localparam logic FUNC_ENCRYPT = 1'b0;
	localparam logic FUNC_DECRYPT = 1'b1;

	// status of the modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

>>> hdl/rsa_modular_exponentiation.sv
// Top level of the RSA modular exponentiation engine (square and multiply).
`timescale 1ns / 1ps
// Computes message^e mod n (func = encrypt) or message^d mod n (func = decrypt).
// n, e and d are APB registers at 0x0, 0x4, 0x8 (reset n = 2, e = d = 1); the user
// must write them only while the engine is idle, which the block itself does not
// enforce. Only the low WORD_BITS bits of the registers and of the message are used.
// A message at or above n is first reduced mod n; for n below 2 the result is 0.
// All arithmetic runs through one bit-serial modular multiplier that retires one
// multiplier bit per cycle. One multiply steps through all WORD_BITS bits of its
// multiplier, and the next multiply is launched in the cycle in which the multiplier
// reports done. Per request: one multiply to reduce the message, then for each of
// the WORD_BITS exponent bits, MSB first, one squaring plus one multiply when the
// bit is set. req_ready is high only while idle, so the next request is taken only
// once the engine is idle again. The result sits in an output register, so a new
// request can be taken while the last result waits for res_ready; the engine stalls
// at the end only if that register is still full.
module rsa_modular_exponentiation import rme_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 func,
	input  logic [31:0]          message,
	// result channel
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [31:0]          result,
	// APB configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int W     = WORD_BITS;
	localparam int CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_SQUARE,
		S_MULT,
		S_OUT
	} state_t;

	// configuration registers
	logic [W-1:0] mod_q;
	logic [W-1:0] pub_q;
	logic [W-1:0] priv_q;

	// sequencer
	state_t           state_q;
	logic [W-1:0]     exp_q;    // exponent, current bit at MSB
	logic [CNT_W-1:0] cnt_q;    // exponent bit position, counted from MSB
	logic [W-1:0]     base_q;   // message mod n
	logic [W-1:0]     acc_q;    // final value waiting for the output register
	logic             res_valid_q;
	logic [31:0]      result_q;

	// multiplier hookup
	logic         mm_start;
	logic [W-1:0] mm_a;
	logic [W-1:0] mm_b;
	logic [W-1:0] mm_res;
	mm_stat_t     mm_stat;

	logic req_acc;
	logic last_bit;
	logic mod_small;
	logic cfg_wr;

	assign req_ready = (state_q == S_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign last_bit  = (cnt_q == LAST);
	assign mod_small = (mod_q < W'(2));
	assign res_valid = res_valid_q;
	assign result    = result_q;

	// ---------------- APB registers ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= W'(2);
			pub_q  <= W'(1);
			priv_q <= W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MODULUS:  mod_q  <= pwdata[W-1:0];
				REG_PUB_EXP:  pub_q  <= pwdata[W-1:0];
				REG_PRIV_EXP: priv_q <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODULUS:  prdata = 32'(mod_q);
			REG_PUB_EXP:  prdata = 32'(pub_q);
			REG_PRIV_EXP: prdata = 32'(priv_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------- multiplier launch ----------------
	// Next multiply is launched in the cycle the previous one reports done.
	always_comb begin
		mm_start = 1'b0;
		mm_a     = mm_res;
		mm_b     = mm_res;
		case (state_q)
			S_IDLE: begin
				// message * 1 mod n reduces the message
				if (req_acc && !mod_small) begin
					mm_start = 1'b1;
					mm_a     = message[W-1:0];
					mm_b     = W'(1);
				end
			end
			S_REDUCE: begin
				// first squaring of the accumulator, which starts at 1
				if (mm_stat.done) begin
					mm_start = 1'b1;
					mm_a     = W'(1);
					mm_b     = W'(1);
				end
			end
			S_SQUARE: begin
				if (mm_stat.done) begin
					if (exp_q[W-1]) begin
						mm_start = 1'b1;
						mm_b     = base_q;
					end else if (!last_bit) begin
						mm_start = 1'b1;
					end
				end
			end
			S_MULT: begin
				if (mm_stat.done && !last_bit) begin
					mm_start = 1'b1;
				end
			end
			default: ;
		endcase
	end

	rme_mulmod #(
		.WORD_BITS(W)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.a     (mm_a),
		.b     (mm_b),
		.n     (mod_q),
		.stat  (mm_stat),
		.res   (mm_res)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						exp_q <= (func == FUNC_DECRYPT) ? priv_q : pub_q;
						cnt_q <= '0;
						if (mod_small) begin
							acc_q   <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					if (mm_stat.done) begin
						base_q  <= mm_res;
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					if (mm_stat.done) begin
						if (exp_q[W-1]) begin
							state_q <= S_MULT;
						end else if (last_bit) begin
							acc_q   <= mm_res;
							state_q <= S_OUT;
						end else begin
							exp_q <= exp_q << 1;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_MULT: begin
					if (mm_stat.done) begin
						if (last_bit) begin
							acc_q   <= mm_res;
							state_q <= S_OUT;
						end else begin
							exp_q   <= exp_q << 1;
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_SQUARE;
						end
					end
				end
				S_OUT: begin
					// wait for the output register to be free
					if (!res_valid_q || res_ready) begin
						result_q    <= 32'(acc_q);
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/rme_mulmod.sv
// Bit-serial interleaved modular multiplier: a * b mod n, one bit of a per cycle.
`timescale 1ns / 1ps
module rme_mulmod import rme_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	input  logic [WORD_BITS-1:0] n,
	output mm_stat_t             stat,
	output logic [WORD_BITS-1:0] res
);

	localparam int W     = WORD_BITS;
	localparam int CNT_W = $clog2(W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [W-1:0]     r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [W+1:0] t;
	logic [W+2:0] d1;
	logic [W+2:0] d2;
	logic [W-1:0] r_nxt;

	// t = 2r + a_i*b < 3n; subtract n or 2n to bring it back below n
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + (a_q[W-1] ? {2'b00, b_q} : '0);
		d1 = {1'b0, t} - {3'b000, n};
		d2 = {1'b0, t} - {2'b00, n, 1'b0};
		if (!d2[W+2]) begin
			r_nxt = d2[W-1:0];
		end else if (!d1[W+2]) begin
			r_nxt = d1[W-1:0];
		end else begin
			r_nxt = t[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				r_q   <= r_nxt;
				a_q   <= a_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				a_q    <= a;
				b_q    <= b;
				r_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign res       = r_q;

endmodule

>>> hdl/rme_checker.sv
// Port-level checker for the RSA exponentiation block, with its bind.
`timescale 1ns / 1ps
`include "rsa_modular_exponentiation_macros.svh"
module rme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] result
);

	`RME_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready, "engine ready right after taking a request")
	`RME_ASSERT_NEXT(a_no_instant_result, clk, arst_n, req_valid && req_ready && !res_valid, !res_valid, "result showed one cycle after request")
	`RME_ASSERT_NOW(a_busy_no_new_result, clk, arst_n, $rose(res_valid), req_ready, "result raised while engine still busy")
	`RME_ASSERT_NEXT(a_result_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(result), "stalled result dropped or changed")

endmodule

bind rsa_modular_exponentiation rme_checker u_rme_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.result   (result)
);
